### sv/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescape / UTF-8 decode block.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Result kinds
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_CLOSED = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Default depth of the group queue between front and back
    localparam int JSU_QUEUE_DEPTH = 4;

    // One accepted input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_item;

    // One delivered result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last;
    } t_out_item;

    // All results caused by one input item; bytes[0] goes out first
    typedef struct packed {
        logic [1:0]      kind;
        logic [1:0]      cnt_m1;
        logic [3:0][7:0] bytes;
    } t_group;

    // Group with its valid flag, as it moves between the parts
    typedef struct packed {
        logic   valid;
        t_group group;
    } t_group_xfer;

endpackage

### sv/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Per-byte string decoder: escape, \u and raw UTF-8 state machine. Each
// accepted byte turns into at most one result group for the queue.
// ----------------------------------------------------------------------------
module jsu_front
    import jsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_in_item    i_item,
    output t_group_xfer o_push
);

    // Decoder phases
    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_BODY       = 3'd1;
    localparam logic [2:0] PH_ESC        = 3'd2;
    localparam logic [2:0] PH_HEX_FIRST  = 3'd3;
    localparam logic [2:0] PH_PAIR_SLASH = 3'd4;
    localparam logic [2:0] PH_PAIR_U     = 3'd5;
    localparam logic [2:0] PH_HEX_SECOND = 3'd6;
    localparam logic [2:0] PH_RAW        = 3'd7;

    // Characters of interest
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    // Hex digit value, bit 4 set for a non-hex character
    function automatic logic [4:0] hex_value(input logic [7:0] ch);
        logic [4:0] v;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            v = 5'(ch - 8'h30);
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            v = 5'(ch - 8'h61 + 8'd10);
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            v = 5'(ch - 8'h41 + 8'd10);
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

    // UTF-8 encoding of a code point as a byte group
    function automatic t_group encode(input logic [20:0] cp);
        t_group g;
        g = '0;
        g.kind = KIND_BYTE;
        if (cp <= 21'h7f) begin
            g.bytes[0] = {1'b0, cp[6:0]};
        end else if (cp <= 21'h7ff) begin
            g.cnt_m1   = 2'd1;
            g.bytes[0] = {3'b110, cp[10:6]};
            g.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hffff) begin
            g.cnt_m1   = 2'd2;
            g.bytes[0] = {4'b1110, cp[15:12]};
            g.bytes[1] = {2'b10, cp[11:6]};
            g.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            g.cnt_m1   = 2'd3;
            g.bytes[0] = {5'b11110, cp[20:18]};
            g.bytes[1] = {2'b10, cp[17:12]};
            g.bytes[2] = {2'b10, cp[11:6]};
            g.bytes[3] = {2'b10, cp[5:0]};
        end
        return g;
    endfunction

    // Single-byte group
    function automatic t_group one_byte(input logic [7:0] b, input logic [1:0] k);
        t_group g;
        g          = '0;
        g.kind     = k;
        g.bytes[0] = b;
        return g;
    endfunction

    logic [2:0]  r_phase, n_phase;
    logic [20:0] r_cp, n_cp;
    logic [9:0]  r_high, n_high;
    logic [1:0]  r_dl, n_dl;
    logic [1:0]  r_mc, n_mc;

    logic [7:0]  ch;
    logic        eoi;
    logic [4:0]  hv;
    logic [15:0] cp_hex;
    logic [20:0] cp_raw;
    logic [20:0] cp_pair;
    logic [20:0] raw_min;
    logic        err;
    logic        has_res;
    t_group      grp;

    assign ch      = i_item.in_byte;
    assign eoi     = i_item.end_of_input;
    assign hv      = hex_value(ch);
    assign cp_hex  = {r_cp[11:0], hv[3:0]};
    assign cp_raw  = {r_cp[14:0], ch[5:0]};
    assign cp_pair = 21'h10000 + {1'b0, r_high, cp_hex[9:0]};

    // Smallest legal value of the raw sequence in progress
    always_comb begin
        case (r_mc)
            2'd0:    raw_min = 21'h80;
            2'd1:    raw_min = 21'h800;
            default: raw_min = 21'h10000;
        endcase
    end

    // Next state and result group for the byte at the input
    always_comb begin
        n_phase = r_phase;
        n_cp    = r_cp;
        n_high  = r_high;
        n_dl    = r_dl;
        n_mc    = r_mc;
        err     = 1'b0;
        has_res = 1'b0;
        grp     = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (ch == CH_QUOTE) begin
                    n_phase = PH_BODY;
                end else begin
                    err = 1'b1;
                end
            end
            PH_BODY: begin
                if (ch == CH_QUOTE) begin
                    grp     = one_byte(8'h00, KIND_CLOSED);
                    has_res = 1'b1;
                    n_phase = PH_IDLE;
                end else if (ch < 8'h20) begin
                    err = 1'b1;
                end else if (ch == CH_BSL) begin
                    n_phase = PH_ESC;
                end else if (ch < 8'h80) begin
                    grp     = one_byte(ch, KIND_BYTE);
                    has_res = 1'b1;
                end else if (ch >= 8'hc2 && ch <= 8'hdf) begin
                    n_cp    = {16'd0, ch[4:0]};
                    n_dl    = 2'd0;
                    n_mc    = 2'd0;
                    n_phase = PH_RAW;
                end else if (ch >= 8'he0 && ch <= 8'hef) begin
                    n_cp    = {17'd0, ch[3:0]};
                    n_dl    = 2'd1;
                    n_mc    = 2'd1;
                    n_phase = PH_RAW;
                end else if (ch >= 8'hf0 && ch <= 8'hf4) begin
                    n_cp    = {18'd0, ch[2:0]};
                    n_dl    = 2'd2;
                    n_mc    = 2'd2;
                    n_phase = PH_RAW;
                end else begin
                    err = 1'b1;
                end
            end
            PH_ESC: begin
                n_phase = PH_BODY;
                case (ch)
                    CH_QUOTE, CH_BSL, CH_SLASH: begin
                        grp     = one_byte(ch, KIND_BYTE);
                        has_res = 1'b1;
                    end
                    CH_B: begin
                        grp     = one_byte(8'h08, KIND_BYTE);
                        has_res = 1'b1;
                    end
                    CH_F: begin
                        grp     = one_byte(8'h0c, KIND_BYTE);
                        has_res = 1'b1;
                    end
                    CH_N: begin
                        grp     = one_byte(8'h0a, KIND_BYTE);
                        has_res = 1'b1;
                    end
                    CH_R: begin
                        grp     = one_byte(8'h0d, KIND_BYTE);
                        has_res = 1'b1;
                    end
                    CH_T: begin
                        grp     = one_byte(8'h09, KIND_BYTE);
                        has_res = 1'b1;
                    end
                    CH_U: begin
                        n_cp    = '0;
                        n_dl    = 2'd3;
                        n_phase = PH_HEX_FIRST;
                    end
                    default: err = 1'b1;
                endcase
            end
            PH_HEX_FIRST, PH_HEX_SECOND: begin
                if (hv[4]) begin
                    err = 1'b1;
                end else begin
                    n_cp = {5'd0, cp_hex};
                    if (r_dl != 2'd0) begin
                        n_dl = r_dl - 2'd1;
                    end else if (r_phase == PH_HEX_FIRST) begin
                        if (cp_hex == 16'h0) begin
                            err = 1'b1;
                        end else if (cp_hex >= 16'hd800 && cp_hex <= 16'hdbff) begin
                            // high surrogate: wait for the low half
                            n_high  = cp_hex[9:0];
                            n_phase = PH_PAIR_SLASH;
                        end else if (cp_hex >= 16'hdc00 && cp_hex <= 16'hdfff) begin
                            err = 1'b1;
                        end else begin
                            grp     = encode({5'd0, cp_hex});
                            has_res = 1'b1;
                            n_phase = PH_BODY;
                        end
                    end else begin
                        if (cp_hex < 16'hdc00 || cp_hex > 16'hdfff) begin
                            err = 1'b1;
                        end else begin
                            n_cp    = cp_pair;
                            grp     = encode(cp_pair);
                            has_res = 1'b1;
                            n_phase = PH_BODY;
                        end
                    end
                end
            end
            PH_PAIR_SLASH: begin
                if (ch == CH_BSL) begin
                    n_phase = PH_PAIR_U;
                end else begin
                    err = 1'b1;
                end
            end
            PH_PAIR_U: begin
                if (ch == CH_U) begin
                    n_cp    = '0;
                    n_dl    = 2'd3;
                    n_phase = PH_HEX_SECOND;
                end else begin
                    err = 1'b1;
                end
            end
            PH_RAW: begin
                if (ch[7:6] != 2'b10) begin
                    err = 1'b1;
                end else begin
                    n_cp = cp_raw;
                    if (r_dl != 2'd0) begin
                        n_dl = r_dl - 2'd1;
                    end else if (cp_raw < raw_min || cp_raw > 21'h10ffff ||
                                 (cp_raw >= 21'hd800 && cp_raw <= 21'hdfff)) begin
                        err = 1'b1;
                    end else begin
                        grp     = encode(cp_raw);
                        has_res = 1'b1;
                        n_phase = PH_BODY;
                    end
                end
            end
            default: err = 1'b1;
        endcase

        // Errors and truncated input replace anything decoded this byte
        if (err || (eoi && n_phase != PH_IDLE)) begin
            grp     = one_byte(8'h00, KIND_ERROR);
            has_res = 1'b1;
            n_phase = PH_IDLE;
        end
    end

    assign o_push.valid = i_accept && has_res;
    assign o_push.group = grp;

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cp    <= '0;
            r_high  <= '0;
            r_dl    <= '0;
            r_mc    <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_cp    <= n_cp;
            r_high  <= n_high;
            r_dl    <= n_dl;
            r_mc    <= n_mc;
        end
    end

endmodule

### sv/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Small FIFO of result groups between the decoder and the serializer.
// ----------------------------------------------------------------------------
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = JSU_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_group_xfer i_push,
    output logic        o_full,
    output t_group_xfer o_head,
    input  logic        i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_group        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full       = (r_cnt == FULL_CNT);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.group = r_mem[r_rd_ptr];

    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_head.valid;

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.group;
        end
    end

endmodule

### sv/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Serializer: walks the head group one result per cycle, unless the output
// stalls, into the output register and marks each group's final result.
// ----------------------------------------------------------------------------
module jsu_back
    import jsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_group_xfer i_head,
    output logic        o_pop,
    output logic        o_valid,
    output t_out_item   o_item,
    input  logic        i_ready
);

    logic [1:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    t_out_item  r_item;
    logic       load;
    logic       at_last;

    assign load    = i_head.valid && (!r_valid || i_ready);
    assign at_last = (r_idx == i_head.group.cnt_m1);
    assign o_pop   = load && at_last;

    // Byte index within the head group and output valid
    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_idx   = at_last ? 2'd0 : r_idx + 2'd1;
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.out_byte <= i_head.group.bytes[r_idx];
            r_item.kind     <= i_head.group.kind;
            r_item.last     <= at_last;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### sv/json_string_unescape_utf8_core.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core
// Streaming decoder for one JSON string token at a time.
//
// Input channel (i_in_valid / o_in_ready, i_in_item): one text byte per item
// plus an end-of-input flag. Output channel (o_out_valid / i_out_ready,
// o_out_item): one decoded UTF-8 byte, a closed status or an error status per
// item; last marks the final result caused by an input byte.
// A byte is decoded in the cycle it is accepted; its results sit in a queue
// of QUEUE_DEPTH groups and leave through a registered output stage. The
// first result of a byte passes through the queue and then the output
// register before it shows on o_out_valid. Input throughput is one byte per
// cycle while the queue has room. Output runs at one result per cycle while
// the receiver is ready, so an escape or raw sequence that expands to N bytes
// holds the serializer until all N have left; the queue absorbs bursts.
// A stalled receiver fills the queue, and o_in_ready drops only when it is
// full. Reset returns the decoder to waiting for an opening quote and
// empties the queue and output stage.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = JSU_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_group_xfer push;
    t_group_xfer head;
    logic        q_full;
    logic        pop;
    logic        in_accept;

    assign o_in_ready = !q_full;
    assign in_accept  = i_in_valid && o_in_ready;

    // Front: per-byte decode
    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_item),
        .o_push   (push)
    );

    // Group queue
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    // Back: serialize results
    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .i_ready (i_out_ready)
    );

`ifndef SYNTH
    // Never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push.valid)
        else $error("push into full group queue");

    // Status results are single and always final
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.kind != KIND_BYTE) |-> o_out_item.last)
        else $error("status result without last");

    // An error group carries exactly one result
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.valid && push.group.kind == KIND_ERROR) |-> push.group.cnt_m1 == 2'd0)
        else $error("error group with extra results");
`endif

endmodule
